/* rtl/iir_bq_pkg.sv */
// shared constants, register indexes and the control word layout of the biquad
// sequencer; no dependencies
`default_nettype none

package iir_bq_pkg;

   localparam int DEF_FILTER_ORDER = 2;
   localparam int DEF_SAMPLE_WIDTH = 16;

   localparam int COEF_WIDTH    = 18;
   localparam int COEF_FRAC     = 14;
   localparam int W_WIDTH       = 24;
   localparam int PROD_WIDTH    = COEF_WIDTH + W_WIDTH;
   localparam int ACC_WIDTH     = PROD_WIDTH + 4;
   localparam int RND_WIDTH     = ACC_WIDTH - COEF_FRAC;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int STEP_WIDTH    = 4;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] REG_FEED_B0 = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_FEED_B1 = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_FEED_B2 = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_BACK_A1 = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_BACK_A2 = 3'd4;

   // coefficient reset values, q4.14
   localparam logic signed [COEF_WIDTH-1:0] RST_FEED_B0 = 18'sd16384;
   localparam logic signed [COEF_WIDTH-1:0] RST_COEF_ZERO = 18'sd0;

   typedef enum logic [2:0] {
      SEL_B0,
      SEL_B1,
      SEL_B2,
      SEL_A1,
      SEL_A2
   } coef_sel_type;

   typedef enum logic [1:0] {
      SEL_W1,
      SEL_W2,
      SEL_W
   } data_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_X,
      ACC_LOAD_BIAS,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   // one microcode word; all zero is a no-op
   typedef struct packed {
      coef_sel_type           coef_sel;
      data_sel_type           data_sel;
      logic                   mul_en;
      acc_op_type             acc_op;
      logic                   w_latch;
      logic                   y_done;
      logic                   skip_short;
      logic [STEP_WIDTH-1:0]  skip_target;
   } ctrl_word_type;

endpackage

`default_nettype wire

/* rtl/iir_bq_seq.sv */
// microcode sequencer of the biquad: step counter, control rom and the
// first-order skip jumps; uses iir_bq_pkg
`default_nettype none

module iir_bq_seq #(
   parameter int FILTER_ORDER = iir_bq_pkg::DEF_FILTER_ORDER
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic                      stall,
   output iir_bq_pkg::ctrl_word_type      cw,
   output logic                           busy
);
   import iir_bq_pkg::*;

   localparam logic SHORT_FILTER = (FILTER_ORDER < 2);

   localparam logic [STEP_WIDTH-1:0] STEP_W_LATCH = 4'd3;
   localparam logic [STEP_WIDTH-1:0] STEP_Y_DONE  = 4'd8;

   logic                  busy_ff, busy_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   ctrl_word_type         rom_word;

   // control program
   always_comb begin
      rom_word = '0;
      case (step_ff)
         4'd0: begin
            rom_word.coef_sel = SEL_A1;
            rom_word.data_sel = SEL_W1;
            rom_word.mul_en   = 1'b1;
            rom_word.acc_op   = ACC_LOAD_X;
         end
         4'd1: begin
            rom_word.coef_sel    = SEL_A2;
            rom_word.data_sel    = SEL_W2;
            rom_word.mul_en      = 1'b1;
            rom_word.acc_op      = ACC_SUB;
            rom_word.skip_short  = 1'b1;
            rom_word.skip_target = STEP_W_LATCH;
         end
         4'd2: begin
            rom_word.acc_op = ACC_SUB;
         end
         4'd3: begin
            rom_word.w_latch = 1'b1;
         end
         4'd4: begin
            rom_word.coef_sel = SEL_B0;
            rom_word.data_sel = SEL_W;
            rom_word.mul_en   = 1'b1;
            rom_word.acc_op   = ACC_LOAD_BIAS;
         end
         4'd5: begin
            rom_word.coef_sel = SEL_B1;
            rom_word.data_sel = SEL_W1;
            rom_word.mul_en   = 1'b1;
            rom_word.acc_op   = ACC_ADD;
         end
         4'd6: begin
            rom_word.coef_sel    = SEL_B2;
            rom_word.data_sel    = SEL_W2;
            rom_word.mul_en      = 1'b1;
            rom_word.acc_op      = ACC_ADD;
            rom_word.skip_short  = 1'b1;
            rom_word.skip_target = STEP_Y_DONE;
         end
         4'd7: begin
            rom_word.acc_op = ACC_ADD;
         end
         4'd8: begin
            rom_word.y_done = 1'b1;
         end
         default: begin
            rom_word = '0;
         end
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff && !stall) begin
         if (rom_word.y_done) begin
            busy_in = 1'b0;
            step_in = '0;
         end else if (rom_word.skip_short && SHORT_FILTER) begin
            step_in = rom_word.skip_target;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign cw   = busy_ff ? rom_word : '0;
   assign busy = busy_ff;

endmodule

`default_nettype wire

/* rtl/iir_direct_form2_biquad.sv */
// direct-form-ii biquad: one request in, one filtered sample out; each request runs as an
// accept cycle plus nine microcode steps over a single 18x24 multiplier and accumulator
// (first order skips two steps); rsp_tvalid rises once the last step registers the result,
// which waits while the previous result is still held on the output; a new request is taken
// once the result is registered
// reset: synchronous active high; coefficients return to b0 = 1.0 and the rest zero,
// the delay pair clears and the output register empties
// depends on iir_bq_pkg and iir_bq_seq
`default_nettype none

module iir_direct_form2_biquad #(
   parameter int FILTER_ORDER = iir_bq_pkg::DEF_FILTER_ORDER,
   parameter int SAMPLE_WIDTH = iir_bq_pkg::DEF_SAMPLE_WIDTH
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   // request channel
   input  wire logic                                       req_tvalid,
   output logic                                            req_tready,
   input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]          req_tdata,   // sample_in
   // result channel
   output logic                                            rsp_tvalid,
   input  wire logic                                       rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]               rsp_tdata,   // sample_out
   output logic                                            rsp_tuser,   // saturated
   // coefficient write port
   input  wire logic                                       csr_wen,
   input  wire logic [iir_bq_pkg::CSR_IDX_WIDTH-1:0]       csr_index,
   input  wire logic [iir_bq_pkg::COEF_WIDTH-1:0]          csr_wdata
);
   import iir_bq_pkg::*;

   localparam int DATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;

   // saturation limits at the width of the rounded sum
   localparam logic signed [RND_WIDTH-1:0] W_MAX = RND_WIDTH'((64'sd1 <<< (W_WIDTH - 1)) - 1);
   localparam logic signed [RND_WIDTH-1:0] W_MIN = -W_MAX - 1;
   localparam logic signed [RND_WIDTH-1:0] Y_MAX =
      RND_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [RND_WIDTH-1:0] Y_MIN = -Y_MAX - 1;

   // half an lsb at q14 scale, for round half up
   localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS = ACC_WIDTH'(64'sd1 <<< (COEF_FRAC - 1));

   // coefficient registers
   logic signed [COEF_WIDTH-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;

   // datapath state
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [W_WIDTH-1:0]      w_ff, w1_ff, w2_ff;
   logic signed [PROD_WIDTH-1:0]   prod_ff, prod_in;
   logic signed [ACC_WIDTH-1:0]    acc_ff, acc_in;
   logic                           clip_ff;

   // output register
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] y_ff;
   logic                           sat_ff;

   ctrl_word_type                  cw;
   logic                           busy;
   logic                           req_take;
   logic                           stall;
   logic                           y_commit;

   logic signed [COEF_WIDTH-1:0]   coef_mux;
   logic signed [W_WIDTH-1:0]      data_mux;
   logic signed [RND_WIDTH-1:0]    rnd;
   logic signed [W_WIDTH-1:0]      w_sat;
   logic                           w_clip;
   logic signed [SAMPLE_WIDTH-1:0] y_sat;
   logic                           y_clip;

   // handshakes
   assign req_tready = !busy;
   assign req_take   = req_tvalid && !busy;
   // the last step waits while the previous result is still unclaimed
   assign stall      = cw.y_done && rsp_valid_ff && !rsp_tready;
   assign y_commit   = cw.y_done && !stall;

   iir_bq_seq #(
      .FILTER_ORDER (FILTER_ORDER)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .start (req_take),
      .stall (stall),
      .cw    (cw),
      .busy  (busy)
   );

   // coefficient writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= RST_FEED_B0;
         b1_ff <= RST_COEF_ZERO;
         b2_ff <= RST_COEF_ZERO;
         a1_ff <= RST_COEF_ZERO;
         a2_ff <= RST_COEF_ZERO;
      end else if (csr_wen) begin
         case (csr_index)
            REG_FEED_B0: b0_ff <= csr_wdata;
            REG_FEED_B1: b1_ff <= csr_wdata;
            REG_FEED_B2: b2_ff <= csr_wdata;
            REG_BACK_A1: a1_ff <= csr_wdata;
            REG_BACK_A2: a2_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // multiplier operand selection
   always_comb begin
      case (cw.coef_sel)
         SEL_B0:  coef_mux = b0_ff;
         SEL_B1:  coef_mux = b1_ff;
         SEL_B2:  coef_mux = b2_ff;
         SEL_A1:  coef_mux = a1_ff;
         SEL_A2:  coef_mux = a2_ff;
         default: coef_mux = b0_ff;
      endcase
      case (cw.data_sel)
         SEL_W1:  data_mux = w1_ff;
         SEL_W2:  data_mux = w2_ff;
         SEL_W:   data_mux = w_ff;
         default: data_mux = w1_ff;
      endcase
   end

   assign prod_in = coef_mux * data_mux;

   // accumulator: the product of one step is folded in on the next
   always_comb begin
      case (cw.acc_op)
         ACC_LOAD_X:    acc_in = (ACC_WIDTH'(x_ff) <<< COEF_FRAC) + ROUND_BIAS;
         ACC_LOAD_BIAS: acc_in = ROUND_BIAS;
         ACC_ADD:       acc_in = acc_ff + ACC_WIDTH'(prod_ff);
         ACC_SUB:       acc_in = acc_ff - ACC_WIDTH'(prod_ff);
         default:       acc_in = acc_ff;
      endcase
   end

   // floor after the bias gives round half up, then clip
   assign rnd = acc_ff[ACC_WIDTH-1:COEF_FRAC];

   always_comb begin
      w_clip = 1'b1;
      if (rnd > W_MAX) begin
         w_sat = W_WIDTH'(W_MAX);
      end else if (rnd < W_MIN) begin
         w_sat = W_WIDTH'(W_MIN);
      end else begin
         w_sat  = W_WIDTH'(rnd);
         w_clip = 1'b0;
      end
   end

   always_comb begin
      y_clip = 1'b1;
      if (rnd > Y_MAX) begin
         y_sat = SAMPLE_WIDTH'(Y_MAX);
      end else if (rnd < Y_MIN) begin
         y_sat = SAMPLE_WIDTH'(Y_MIN);
      end else begin
         y_sat  = SAMPLE_WIDTH'(rnd);
         y_clip = 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff    <= req_tdata[SAMPLE_WIDTH-1:0];
         clip_ff <= 1'b0;
      end else if (cw.w_latch) begin
         clip_ff <= w_clip;
      end
      if (cw.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (cw.w_latch) begin
         w_ff <= w_sat;
      end
      if (y_commit) begin
         y_ff   <= y_sat;
         sat_ff <= clip_ff || y_clip;
      end
   end

   // delay pair shifts once the result is registered
   always_ff @(posedge clock) begin
      if (reset) begin
         w1_ff <= '0;
         w2_ff <= '0;
      end else if (y_commit) begin
         w2_ff <= w1_ff;
         w1_ff <= w_ff;
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (y_commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_WIDTH'($unsigned(y_ff));
   assign rsp_tuser  = sat_ff;

endmodule

`default_nettype wire

/* bench/tb_iir_direct_form2_biquad.sv */
`timescale 1ns / 100ps
// self-checking bench for iir_direct_form2_biquad: streams samples through the filter under
// changing coefficient sets and flow control, and checks every filtered sample against a
// fixed-point model of the biquad kept here; depends on iir_bq_pkg and the rtl of the block
module tb_iir_direct_form2_biquad;
   import iir_bq_pkg::*;

   localparam int SW           = DEF_SAMPLE_WIDTH;
   localparam int TDATA_W      = ((SW + 7) / 8) * 8;
   localparam int NUM_COEFS    = int'(REG_BACK_A2) + 1;
   localparam int NUM_INDEXES  = 1 << CSR_IDX_WIDTH;
   localparam int CYCLE_LIMIT  = 250000;
   localparam int DRAIN_CYCLES = 30;    // settle time after the pipe runs dry
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off for the back-pressure phase
   localparam int RAND_PHASES  = 10;
   localparam int PHASE_ITEMS  = 100;
   localparam int HOLD_ITEMS   = 60;

   localparam logic signed [COEF_WIDTH-1:0] COEF_MAX  = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   localparam logic signed [COEF_WIDTH-1:0] COEF_MIN  = {1'b1, {(COEF_WIDTH-1){1'b0}}};
   localparam logic signed [COEF_WIDTH-1:0] COEF_HALF = RST_FEED_B0 >>> 1;
   localparam logic signed [SW-1:0]         SMP_MAX   = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0]         SMP_MIN   = {1'b1, {(SW-1){1'b0}}};

   // flow-control mixes used across the phases
   typedef enum int {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic signed [SW-1:0] sample;
      logic                 clip;
   } filtered_type;

   // dut signals, all inputs known from time zero
   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_tvalid  = 1'b0;
   logic                         req_tready;
   logic [TDATA_W-1:0]           req_tdata   = '0;      // sample_in
   logic                         rsp_tvalid;
   logic                         rsp_tready  = 1'b0;
   logic [TDATA_W-1:0]           rsp_tdata;             // sample_out
   logic                         rsp_tuser;             // saturated
   logic                         csr_wen     = 1'b0;
   logic [CSR_IDX_WIDTH-1:0]     csr_index   = REG_FEED_B0;
   logic [COEF_WIDTH-1:0]        csr_wdata   = '0;

   // bench state
   logic signed [SW-1:0]         sample_q[$];           // samples waiting to be offered
   filtered_type                 filtered_q[$];         // predicted outputs, oldest first
   logic signed [COEF_WIDTH-1:0] coef_reg[NUM_COEFS];   // mirror of the coefficient registers
   longint                       dly_w1;                // mirror of the delay pair
   longint                       dly_w2;
   idle_mode_type                idle_mode   = IDLE_NONE;
   logic                         stall_go    = 1'b0;
   int                           stall_left  = 0;
   int                           errors      = 0;
   int                           cycle_count = 0;

   always #5 clock = ~clock;

   iir_direct_form2_biquad u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // biquad model
   // -------------------------------------------------------------------------

   // floor((acc + 2^13) / 2^14): round half toward plus infinity
   function automatic longint round_half_up(input longint acc);
      return (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
   endfunction

   // clamp to a signed width, flagging the clip
   function automatic longint clip_to(input longint v, input int width, inout logic hit);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (width - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         hit = 1'b1;
         return hi;
      end
      if (v < lo) begin
         hit = 1'b1;
         return lo;
      end
      return v;
   endfunction

   // one filter step: feedback sum gives w, feed-forward sum gives y, then the delay shifts
   function automatic filtered_type biquad_step(input logic signed [SW-1:0] x);
      longint       acc;
      longint       w_new;
      longint       y_new;
      logic         hit;
      filtered_type r;
      hit   = 1'b0;
      acc   = (longint'(x) <<< COEF_FRAC)
            - longint'(coef_reg[REG_BACK_A1]) * dly_w1
            - longint'(coef_reg[REG_BACK_A2]) * dly_w2;
      w_new = clip_to(round_half_up(acc), W_WIDTH, hit);
      acc   = longint'(coef_reg[REG_FEED_B0]) * w_new
            + longint'(coef_reg[REG_FEED_B1]) * dly_w1
            + longint'(coef_reg[REG_FEED_B2]) * dly_w2;
      y_new = clip_to(round_half_up(acc), SW, hit);
      dly_w2 = dly_w1;
      dly_w1 = w_new;
      r.sample = y_new[SW-1:0];
      r.clip   = hit;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // flow control
   // -------------------------------------------------------------------------

   // true when the given side should sit out this cycle
   function automatic logic idle_roll(input idle_mode_type m, input logic sender);
      case (m)
         IDLE_SEND: return sender && ($urandom_range(99) < 63);
         IDLE_RECV: return !sender && ($urandom_range(99) < 63);
         IDLE_BOTH: return $urandom_range(99) < 23;
         default:   return 1'b0;
      endcase
   endfunction

   // request driver: holds a sample until taken, then offers the next one or idles
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // the model advances exactly when the block takes a request
         if (req_tvalid && req_tready) begin
            filtered_q.push_back(biquad_step(req_tdata[SW-1:0]));
         end
         if (!req_tvalid || req_tready) begin
            if (sample_q.size() != 0 && !idle_roll(idle_mode, 1'b1)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= TDATA_W'($unsigned(sample_q.pop_front()));
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long hold-off of the result channel, counted down here
   always @(posedge clock) begin
      if (stall_go) begin
         stall_left <= HOLD_CYCLES;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // result monitor: every accepted output is matched against the oldest prediction
   always @(posedge clock) begin
      filtered_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (filtered_q.size() == 0) begin
               $error("output with no request pending: sample_out %0d saturated %0b",
                      $signed(rsp_tdata[SW-1:0]), rsp_tuser);
               errors++;
            end else begin
               want = filtered_q.pop_front();
               if (rsp_tdata[SW-1:0] !== want.sample) begin
                  $error("sample_out mismatch: expected %0d, actual %0d",
                         want.sample, $signed(rsp_tdata[SW-1:0]));
                  errors++;
               end
               if (rsp_tuser !== want.clip) begin
                  $error("saturated mismatch: expected %0b, actual %0b", want.clip, rsp_tuser);
                  errors++;
               end
            end
         end
         rsp_tready <= (stall_left == 0) && !stall_go && !idle_roll(idle_mode, 1'b0);
      end
   end

   // runaway guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL iir_direct_form2_biquad");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------

   // one register write; out-of-range indexes leave the mirror alone
   task automatic write_coef(input logic [CSR_IDX_WIDTH-1:0] idx,
                             input logic [COEF_WIDTH-1:0] val);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen   <= 1'b0;
      if (idx <= REG_BACK_A2) coef_reg[idx] = val;
   endtask

   task automatic load_coefs(input logic signed [COEF_WIDTH-1:0] b0, b1, b2, a1, a2);
      write_coef(REG_FEED_B0, b0);
      write_coef(REG_FEED_B1, b1);
      write_coef(REG_FEED_B2, b2);
      write_coef(REG_BACK_A1, a1);
      write_coef(REG_BACK_A2, a2);
   endtask

   // wait for the pipe to run dry, then let the block settle before touching registers
   task automatic wait_idle();
      do @(posedge clock);
      while (sample_q.size() != 0 || req_tvalid || filtered_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // full-scale noise, small signals near zero and the rails
   function automatic logic signed [SW-1:0] pick_sample();
      int v;
      case ($urandom_range(3))
         0, 1: v = int'($urandom);
         2:    v = int'($urandom_range(0, 512)) - 256;
         default: return $urandom_range(1) ? SMP_MAX : SMP_MIN;
      endcase
      return v[SW-1:0];
   endfunction

   // any bit pattern, with the extremes favored
   function automatic logic signed [COEF_WIDTH-1:0] wild_coef();
      if ($urandom_range(3) == 0) return $urandom_range(1) ? COEF_MAX : COEF_MIN;
      return COEF_WIDTH'($urandom);
   endfunction

   // feed-forward gain within +-1.0
   function automatic logic signed [COEF_WIDTH-1:0] tame_coef();
      int v;
      v = int'($urandom_range(0, 2 * 16384)) - 16384;
      return v[COEF_WIDTH-1:0];
   endfunction

   // stable sets keep the poles inside the triangle |a2| < 1, |a1| < 1 + a2
   task automatic load_random_coefs(input logic stable);
      int a1;
      int a2;
      int lim;
      if (stable) begin
         a2  = int'($urandom_range(0, 28000)) - 14000;
         lim = 16384 + a2 - 500;
         a1  = int'($urandom_range(0, 2 * lim)) - lim;
         load_coefs(tame_coef(), tame_coef(), tame_coef(),
                    a1[COEF_WIDTH-1:0], a2[COEF_WIDTH-1:0]);
      end else begin
         load_coefs(wild_coef(), wild_coef(), wild_coef(), wild_coef(), wild_coef());
      end
   endtask

   task automatic random_phase(input idle_mode_type m, input int count, input logic stable);
      load_random_coefs(stable);
      idle_mode = m;
      repeat (count) sample_q.push_back(pick_sample());
      wait_idle();
   endtask

   initial begin
      // model matches the block's reset: b0 = 1.0, the rest zero, delay clear
      coef_reg[REG_FEED_B0] = RST_FEED_B0;
      coef_reg[REG_FEED_B1] = RST_COEF_ZERO;
      coef_reg[REG_FEED_B2] = RST_COEF_ZERO;
      coef_reg[REG_BACK_A1] = RST_COEF_ZERO;
      coef_reg[REG_BACK_A2] = RST_COEF_ZERO;
      dly_w1 = 0;
      dly_w2 = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset coefficients pass the sample straight through
      sample_q = '{16'sd0, SMP_MAX, SMP_MIN, 16'sd1, -16'sd1, 16'sh5555, 16'shAAAA};
      wait_idle();

      // half gain on odd samples lands exactly on the rounding midpoint
      load_coefs(COEF_HALF, RST_COEF_ZERO, RST_COEF_ZERO, RST_COEF_ZERO, RST_COEF_ZERO);
      sample_q = '{16'sd1, -16'sd1, 16'sd3, -16'sd3};
      wait_idle();

      // coefficient extremes with the feedback running away: w and y both clip
      load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
      sample_q = '{SMP_MAX, SMP_MAX, SMP_MIN, SMP_MIN, 16'sd0, 16'sd0};
      wait_idle();

      // opposite extremes, then writes to unused indexes must change nothing
      load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
      for (int idx = int'(REG_BACK_A2) + 1; idx < NUM_INDEXES; idx++) begin
         write_coef(CSR_IDX_WIDTH'(idx), COEF_WIDTH'($urandom));
      end
      sample_q = '{16'sd1000, -16'sd1000, SMP_MAX, -16'sd1, 16'sd0, 16'sd7};
      wait_idle();

      // random coefficient sets, cycling through the flow-control mixes
      for (int p = 0; p < RAND_PHASES; p++) begin
         random_phase(idle_mode_type'(p % 4), PHASE_ITEMS, (p % 3) != 2);
      end

      // back-pressure: sender keeps offering while the receiver holds off for a long time
      load_random_coefs(1'b1);
      idle_mode = IDLE_NONE;
      repeat (HOLD_ITEMS) sample_q.push_back(pick_sample());
      @(posedge clock);
      stall_go <= 1'b1;
      @(posedge clock);
      stall_go <= 1'b0;
      wait_idle();

      // one last wild coefficient set, unthrottled, to close out
      random_phase(IDLE_NONE, PHASE_ITEMS, 1'b0);

      if (errors == 0) begin
         $display("PASS iir_direct_form2_biquad");
      end else begin
         $display("FAIL iir_direct_form2_biquad");
      end
      $finish;
   end

endmodule
